// File: rtl/tcpc_pkg.sv
`default_nettype none

package tcpc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;

  // next-header value of the pseudo-header
  localparam logic [WordW-1:0] NextHdrTcp = 16'd6;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             is_last;
    logic [WordW-1:0] tcp_length;
  } in_item_t;

  // end-around-carry fold of a sum of up to four 16-bit words
  function automatic logic [WordW-1:0] oc_fold(input logic [WordW+1:0] t);
    logic [WordW:0] s;
    s = {1'b0, t[WordW-1:0]} + {{(WordW-1){1'b0}}, t[WordW+1:WordW]};
    return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/tcp_ipv6_checksum.sv
`default_nettype none

// channel  | valid / ready           | payload
// ---------+-------------------------+--------------------------------------
// in       | in_valid_i / in_ready_o | data_byte_i, is_last_i, tcp_length_i
// out      | out_valid_o/out_ready_i | checksum_o
//
// one byte per cycle unless a pending result holds a last byte in the input register;
// a request is registered, then summed when it leaves the input register
// the checksum and out_valid_o are registered when the last byte leaves that register
// reset clears the running sum, parity and both valid flags
// a stalled result holds only a last byte; earlier non-last bytes keep flowing

module tcp_ipv6_checksum (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [tcpc_pkg::ByteW-1:0] data_byte_i,
  input  wire logic                       is_last_i,
  input  wire logic [tcpc_pkg::WordW-1:0] tcp_length_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [tcpc_pkg::WordW-1:0]      checksum_o
);
  import tcpc_pkg::*;

  in_item_t         in_q;
  logic             in_valid_q;
  logic             out_valid_q;
  logic [WordW-1:0] checksum_q;
  logic [WordW-1:0] checksum_d;
  logic             advance;

  // a non-last byte never needs the output register
  assign advance = in_valid_q && (!in_q.is_last || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  tcpc_keeper u_keeper (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (in_q),
    .checksum_o (checksum_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance && in_q.is_last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= '{data_byte: data_byte_i, is_last: is_last_i, tcp_length: tcp_length_i};
    end
    if (advance && in_q.is_last) begin
      checksum_q <= checksum_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign checksum_o  = checksum_q;

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input register empty but not ready");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.is_last |=> out_valid_o)
    else $error("last byte produced no checksum");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !(advance && in_q.is_last))
    else $error("pending checksum overwritten");

endmodule

`default_nettype wire

// File: rtl/tcpc_keeper.sv
`default_nettype none

module tcpc_keeper (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire tcpc_pkg::in_item_t         item_i,
  output logic [tcpc_pkg::WordW-1:0]      checksum_o
);
  import tcpc_pkg::*;

  logic [WordW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] pending_q;
  logic             odd_q, odd_d;
  logic [WordW-1:0] word;
  logic [WordW+1:0] total;

  // even position is the high byte; a lone trailing byte gets a zero low byte
  assign word = odd_q ? {pending_q, item_i.data_byte} : {item_i.data_byte, {ByteW{1'b0}}};

  // running sum plus the closing word, length and next header in one add
  assign total = {2'b00, sum_q} + {2'b00, word} + {2'b00, item_i.tcp_length}
               + {2'b00, NextHdrTcp};

  assign checksum_o = ~oc_fold(total);

  always_comb begin
    sum_d = sum_q;
    odd_d = odd_q;
    if (step_i) begin
      if (item_i.is_last) begin
        sum_d = '0;
        odd_d = 1'b0;
      end else begin
        odd_d = ~odd_q;
        if (odd_q) begin
          sum_d = oc_fold({2'b00, sum_q} + {2'b00, word});
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      odd_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      odd_q <= odd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && !odd_q) begin
      pending_q <= item_i.data_byte;
    end
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.is_last |=> !odd_q && sum_q == '0)
    else $error("packet state not cleared after last byte");

  a_parity_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.is_last |=> odd_q != $past(odd_q))
    else $error("byte parity did not advance");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(sum_q) && $stable(odd_q))
    else $error("keeper state moved without a request");

endmodule

`default_nettype wire

// File: verif/tcp_ipv6_checksum_test.sv
module tcp_ipv6_checksum_test;

  import tcpc_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned DirRows = 16;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic [WordW-1:0] length;
    logic             known;
    logic [WordW-1:0] csum;
  } dir_row_t;

  // rows with known set carry a checksum worked out by hand
  localparam dir_row_t DirTab [DirRows] = '{
    '{8'h00, 1'b1, 16'h0000, 1'b1, 16'hFFF9},  // lone zero byte, zero length
    '{8'hFF, 1'b1, 16'hFFFF, 1'b1, 16'h00F9},  // lone byte padded, max length
    '{8'hFF, 1'b0, 16'h1234, 1'b0, 16'h0000},  // length ignored when not last
    '{8'hFF, 1'b1, 16'hFFF9, 1'b1, 16'h0000},  // sum folds to all ones
    '{8'h12, 1'b0, 16'hABCD, 1'b0, 16'h0000},
    '{8'h34, 1'b0, 16'h0000, 1'b0, 16'h0000},
    '{8'h56, 1'b1, 16'h0003, 1'b0, 16'h0000},  // odd trailing byte
    '{8'h80, 1'b0, 16'h0000, 1'b0, 16'h0000},
    '{8'h01, 1'b0, 16'h0000, 1'b0, 16'h0000},
    '{8'h7F, 1'b0, 16'h0000, 1'b0, 16'h0000},
    '{8'hFE, 1'b1, 16'h8000, 1'b0, 16'h0000},
    '{8'h00, 1'b0, 16'hFFFF, 1'b0, 16'h0000},
    '{8'h00, 1'b1, 16'h0000, 1'b1, 16'hFFF9},  // zero word, zero length
    '{8'hAA, 1'b0, 16'h5555, 1'b0, 16'h0000},
    '{8'h55, 1'b0, 16'hAAAA, 1'b0, 16'h0000},
    '{8'h01, 1'b1, 16'hFFFF, 1'b0, 16'h0000}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] data_byte_i = '0;
  logic             is_last_i = 1'b0;
  logic [WordW-1:0] tcp_length_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [WordW-1:0] checksum_o;

  // hand-worked checksum travelling with the request, if any
  logic             row_known = 1'b0;
  logic [WordW-1:0] row_csum = '0;

  logic [WordW-1:0] csum_q [$];
  logic [WordW-1:0] acc_sum = '0;
  logic [ByteW-1:0] hi_byte = '0;
  logic             hi_held = 1'b0;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned packets_sent = 0;
  int unsigned burst_left = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned pat_age = 0;
  logic [31:0] stall_pat = '0;
  logic [4:0]  pat_idx = '0;

  tcp_ipv6_checksum i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .is_last_i   (is_last_i),
    .tcp_length_i(tcp_length_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .checksum_o  (checksum_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [WordW-1:0] ones_add(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
  endfunction

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    $display("mismatch at cycle %0d: %s, got %h, want %h", cycles, what, got, want);
    errors++;
  endtask

  // checksum predictor, fed by every accepted request
  always @(posedge clk_i) begin : predict_checksum
    logic [WordW-1:0] t;
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (hi_held) begin
        acc_sum = ones_add(acc_sum, {hi_byte, data_byte_i});
        hi_held = 1'b0;
      end else begin
        hi_byte = data_byte_i;
        hi_held = 1'b1;
      end
      if (is_last_i) begin
        t = acc_sum;
        if (hi_held) t = ones_add(t, {hi_byte, 8'h00});
        t = ones_add(t, tcp_length_i);
        t = ones_add(t, NextHdrTcp);
        csum_q.push_back(row_known ? row_csum : ~t);
        acc_sum = '0;
        hi_byte = '0;
        hi_held = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_checksum
    logic [WordW-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (csum_q.size() == 0) begin
        report_mismatch("checksum with no packet pending", checksum_o, '0);
      end else begin
        want = csum_q.pop_front();
        if (checksum_o !== want) report_mismatch("checksum", checksum_o, want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d checksums pending", cycles, csum_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: stall patterns that change now and then, plus requested long holds
  always @(negedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
        pat_age = $urandom_range(64, 512);
      end
      pat_age--;
      out_ready_i <= !stall_pat[pat_idx];
      pat_idx++;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer(input logic [ByteW-1:0] b, input logic lst,
                       input logic [WordW-1:0] len, input logic known,
                       input logic [WordW-1:0] csum);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    is_last_i <= lst;
    tcp_length_i <= len;
    row_known <= known;
    row_csum <= csum;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // well-formed packets carry 32 address bytes and the true segment length
  task automatic send_packet(input int unsigned nbytes, input logic good_len);
    logic [WordW-1:0] len;
    for (int unsigned i = 0; i < nbytes; i++) begin
      len = WordW'($urandom);
      if (i == nbytes - 1 && good_len && nbytes >= 32) len = WordW'(nbytes - 32);
      offer(ByteW'($urandom), i == nbytes - 1, len, 1'b0, '0);
    end
    packets_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (csum_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    int unsigned kind;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int unsigned i = 0; i < DirRows; i++) begin
      offer(DirTab[i].data, DirTab[i].last, DirTab[i].length,
            DirTab[i].known, DirTab[i].csum);
    end
    drain();

    // receiver held off while short packets are offered back to back until the pending result stalls the input
    hold_reqs++;
    burst_left = 200;
    for (int unsigned i = 0; i < 10; i++) send_packet($urandom_range(1, 3), 1'b0);
    drain();

    while (bytes_sent < 1200 || packets_sent < 24) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        send_packet(32 + (($urandom_range(0, 7) == 0) ? $urandom_range(41, 300)
                                                      : $urandom_range(0, 40)), 1'b1);
      end else if (kind == 7) begin
        send_packet($urandom_range(1, 31), 1'b0);
      end else begin
        send_packet(32 + $urandom_range(0, 40), 1'b0);
      end
      if (packets_sent == 20) drain();
    end

    in_valid_i <= 1'b0;
    while (csum_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tcpc_pkg.sv
rtl/tcpc_keeper.sv
rtl/tcp_ipv6_checksum.sv
verif/tcp_ipv6_checksum_test.sv
